// File: sv/midpoint_circle_rasterizer_core_macros.svh
// Assertion macros shared by the midpoint circle rasterizer modules.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_CORE_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MCR_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("midpoint circle rasterizer: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("midpoint circle rasterizer: next-cycle assertion failed");

`endif

// File: sv/mcr_pkg.sv
// Package: shared constants and types of the midpoint circle rasterizer.
package mcr_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;

    // Command queue depth between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Decision loop constants.
    localparam int D_INIT      = 3;
    localparam int STEP_DIAG   = 10;
    localparam int STEP_AXIAL  = 6;

    // Control of the queue head seen by the back end.
    typedef struct packed {
        logic valid;
        logic start;
        logic fill;
    } cmd_ctl_t;

endpackage

// File: sv/midpoint_circle_rasterizer_core.sv
// Top level of the midpoint circle rasterizer: front queue plus loop back end.
//
// Usage:
//   Input channel (s_*): one word per command. operation = start loads the
//   centre, radius and fill mode and arms the loop; it yields no output.
//   operation = tick asks for the next primitive of the current circle.
//   A tick while no circle is active is consumed and yields nothing; a start
//   during a circle drops it and begins the new one.
//   Output channel (m_*): one primitive per busy tick, a point (start equals
//   end) in outline mode or a horizontal span in fill mode. last_of_circle
//   marks the final primitive; after it the block is idle.
//   Path: an accepted tick goes into the command queue, then into the output
//   register when that is free. Throughput: one word per clock while m_ready
//   stays high; each tick needs at most one decision-loop step (one adder chain).
//   A two-entry command queue sits between the input side and the loop, and
//   the result register sits on the output, so the sender keeps going while
//   a finished word waits; a stalled receiver fills the queue and then drops
//   s_ready until m_ready returns.
//   Reset (aresetn low, synchronous) empties the queue and the output
//   register and leaves the block idle.
module midpoint_circle_rasterizer_core #(
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic signed [COORD_BITS-1:0]  s_center_x,
    input  logic signed [COORD_BITS-1:0]  s_center_y,
    input  logic        [RADIUS_BITS-1:0] s_radius,
    input  logic                          s_fill_mode,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS:0]    m_x_start,
    output logic signed [COORD_BITS:0]    m_y_start,
    output logic signed [COORD_BITS:0]    m_x_end,
    output logic signed [COORD_BITS:0]    m_y_end,
    output logic                          m_last_of_circle
);

    // Queue head handed from front to back.
    mcr_pkg::cmd_ctl_t                cmd_ctl;
    logic signed [COORD_BITS-1:0]     cmd_center_x;
    logic signed [COORD_BITS-1:0]     cmd_center_y;
    logic        [RADIUS_BITS-1:0]    cmd_radius;
    logic                             cmd_pop;

    // Front: classify start/tick and queue the word.
    mcr_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_center_x   (s_center_x),
        .s_center_y   (s_center_y),
        .s_radius     (s_radius),
        .s_fill_mode  (s_fill_mode),
        .cmd_ctl      (cmd_ctl),
        .cmd_center_x (cmd_center_x),
        .cmd_center_y (cmd_center_y),
        .cmd_radius   (cmd_radius),
        .cmd_pop      (cmd_pop)
    );

    // Back: decision loop, octant mirroring, output register.
    mcr_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_ctl          (cmd_ctl),
        .cmd_center_x     (cmd_center_x),
        .cmd_center_y     (cmd_center_y),
        .cmd_radius       (cmd_radius),
        .cmd_pop          (cmd_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_x_start        (m_x_start),
        .m_y_start        (m_y_start),
        .m_x_end          (m_x_end),
        .m_y_end          (m_y_end),
        .m_last_of_circle (m_last_of_circle)
    );

endmodule

// File: sv/mcr_front.sv
// Front end: accepts input words, classifies them and queues the commands.
`include "midpoint_circle_rasterizer_core_macros.svh"

module mcr_front #(
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic signed [COORD_BITS-1:0]  s_center_x,
    input  logic signed [COORD_BITS-1:0]  s_center_y,
    input  logic        [RADIUS_BITS-1:0] s_radius,
    input  logic                          s_fill_mode,
    output mcr_pkg::cmd_ctl_t             cmd_ctl,
    output logic signed [COORD_BITS-1:0]  cmd_center_x,
    output logic signed [COORD_BITS-1:0]  cmd_center_y,
    output logic        [RADIUS_BITS-1:0] cmd_radius,
    input  logic                          cmd_pop
);

    localparam int DEPTH = mcr_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EW    = 2 + 2 * COORD_BITS + RADIUS_BITS;

    logic [EW-1:0] entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push;
    logic [EW-1:0] head;
    logic [EW-1:0] new_entry;

    assign s_ready = (cnt_reg < CW'(DEPTH));
    assign push    = s_valid && s_ready;

    // start flag, fill flag, centre x, centre y, radius
    assign new_entry = {(s_operation == mcr_pkg::OP_START), s_fill_mode,
                        s_center_x, s_center_y, s_radius};

    assign head          = entry_reg[rd_ptr_reg];
    assign cmd_ctl.valid = (cnt_reg != '0);
    assign cmd_ctl.start = head[EW-1];
    assign cmd_ctl.fill  = head[EW-2];
    assign cmd_center_x  = head[EW-3 -: COORD_BITS];
    assign cmd_center_y  = head[EW-3-COORD_BITS -: COORD_BITS];
    assign cmd_radius    = head[RADIUS_BITS-1:0];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && cmd_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

    `MCR_ASSERT(a_pop_needs_entry, aclk, aresetn, cmd_pop, cnt_reg != '0)
    `MCR_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !cmd_pop,
                     cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

// File: sv/mcr_back.sv
// Back end: midpoint decision loop, mirroring and output register.
`include "midpoint_circle_rasterizer_core_macros.svh"

module mcr_back #(
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mcr_pkg::cmd_ctl_t             cmd_ctl,
    input  logic signed [COORD_BITS-1:0]  cmd_center_x,
    input  logic signed [COORD_BITS-1:0]  cmd_center_y,
    input  logic        [RADIUS_BITS-1:0] cmd_radius,
    output logic                          cmd_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS:0]    m_x_start,
    output logic signed [COORD_BITS:0]    m_y_start,
    output logic signed [COORD_BITS:0]    m_x_end,
    output logic signed [COORD_BITS:0]    m_y_end,
    output logic                          m_last_of_circle
);

    localparam int OW = COORD_BITS + 1;
    localparam int XW = RADIUS_BITS + 1;
    localparam int DW = RADIUS_BITS + 6;
    localparam int SW = ((COORD_BITS > XW) ? COORD_BITS : XW) + 2;

    logic [XW-1:0]          x_reg, x_next;
    logic [XW-1:0]          y_reg, y_next;
    logic signed [DW-1:0]   d_reg, d_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic                   fill_reg, fill_next;
    logic [2:0]             mi_reg, mi_next;
    logic                   busy_reg, busy_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OW-1:0]          xs_reg, ys_reg, xe_reg, ye_reg;
    logic                   last_reg;

    logic                   slot_free;
    logic                   emit;
    logic                   set_done;
    logic                   circle_done;
    logic [XW-1:0]          x_inc, y_dec;
    logic [XW:0]            diff_new;
    logic [XW:0]            x_inc_w;
    logic signed [DW-1:0]   d_diag, d_axial, d_init;
    logic                   d_pos;
    logic [SW-1:0]          cx_w, cy_w;
    logic [SW-1:0]          off_h, off_v;
    logic [SW-1:0]          sum_xs, sum_ys, sum_xe;
    logic                   neg_h, neg_v;

    assign slot_free = !out_valid_reg || m_ready;
    assign cmd_pop   = cmd_ctl.valid && slot_free;
    assign emit      = cmd_pop && !cmd_ctl.start && busy_reg;

    // y is two's complement: a zero radius steps it to -1 for the closing set.
    assign set_done    = fill_reg ? (mi_reg >= 3'd3) : (mi_reg == 3'd7);
    assign circle_done = set_done && ($signed(y_reg) < $signed(x_reg));

    // Decision update with the already stepped x and y.
    assign x_inc    = x_reg + 1'b1;
    assign y_dec    = y_reg - 1'b1;
    assign diff_new = {1'b0, x_inc} - {y_dec[XW-1], y_dec};
    assign x_inc_w  = {1'b0, x_inc};
    assign d_diag   = d_reg + {{(DW-XW-3){diff_new[XW]}}, diff_new, 2'b00}
                      + DW'(mcr_pkg::STEP_DIAG);
    assign d_axial  = d_reg + {{(DW-XW-3){1'b0}}, x_inc_w, 2'b00}
                      + DW'(mcr_pkg::STEP_AXIAL);
    assign d_init   = DW'(mcr_pkg::D_INIT) - {{(DW-RADIUS_BITS-1){1'b0}}, cmd_radius, 1'b0};
    assign d_pos    = !d_reg[DW-1] && (d_reg != '0);

    // Mirror selection.
    assign cx_w = {{(SW-COORD_BITS){cx_reg[COORD_BITS-1]}}, cx_reg};
    assign cy_w = {{(SW-COORD_BITS){cy_reg[COORD_BITS-1]}}, cy_reg};

    always_comb begin
        if (fill_reg) begin
            off_h = mi_reg[1] ? {{(SW-XW){y_reg[XW-1]}}, y_reg} : {{(SW-XW){1'b0}}, x_reg};
            off_v = mi_reg[1] ? {{(SW-XW){1'b0}}, x_reg} : {{(SW-XW){y_reg[XW-1]}}, y_reg};
            neg_h = 1'b0;
            neg_v = mi_reg[0];
        end else begin
            off_h = mi_reg[2] ? {{(SW-XW){y_reg[XW-1]}}, y_reg} : {{(SW-XW){1'b0}}, x_reg};
            off_v = mi_reg[2] ? {{(SW-XW){1'b0}}, x_reg} : {{(SW-XW){y_reg[XW-1]}}, y_reg};
            neg_h = mi_reg[0];
            neg_v = mi_reg[1];
        end
    end

    assign sum_xs = neg_h ? cx_w - off_h : cx_w + off_h;
    assign sum_ys = neg_v ? cy_w - off_v : cy_w + off_v;
    assign sum_xe = fill_reg ? cx_w - off_h : sum_xs;

    always_comb begin
        x_next         = x_reg;
        y_next         = y_reg;
        d_next         = d_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        fill_next      = fill_reg;
        mi_next        = mi_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cmd_pop && cmd_ctl.start) begin
            cx_next   = cmd_center_x;
            cy_next   = cmd_center_y;
            fill_next = cmd_ctl.fill;
            x_next    = '0;
            y_next    = {1'b0, cmd_radius};
            d_next    = d_init;
            mi_next   = '0;
            busy_next = 1'b1;
        end else if (emit) begin
            out_valid_next = 1'b1;
            if (!set_done) begin
                mi_next = mi_reg + 1'b1;
            end else if (circle_done) begin
                mi_next   = '0;
                busy_next = 1'b0;
            end else begin
                mi_next = '0;
                x_next  = x_inc;
                if (d_pos) begin
                    y_next = y_dec;
                    d_next = d_diag;
                end else begin
                    d_next = d_axial;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg         <= '0;
            y_reg         <= '0;
            d_reg         <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            fill_reg      <= 1'b0;
            mi_reg        <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            d_reg         <= d_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            fill_reg      <= fill_next;
            mi_reg        <= mi_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            xs_reg   <= sum_xs[OW-1:0];
            ys_reg   <= sum_ys[OW-1:0];
            xe_reg   <= sum_xe[OW-1:0];
            ye_reg   <= sum_ys[OW-1:0];
            last_reg <= circle_done;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_x_start        = xs_reg;
    assign m_y_start        = ys_reg;
    assign m_x_end          = xe_reg;
    assign m_y_end          = ye_reg;
    assign m_last_of_circle = last_reg;

    `MCR_ASSERT(a_fill_index, aclk, aresetn, busy_reg && fill_reg, mi_reg <= 3'd3)
    `MCR_ASSERT_NEXT(a_start_arms, aclk, aresetn, cmd_pop && cmd_ctl.start,
                     busy_reg && (mi_reg == '0) && (x_reg == '0))
    `MCR_ASSERT_NEXT(a_done_idles, aclk, aresetn, emit && circle_done,
                     !busy_reg && m_valid && m_last_of_circle)

endmodule

// File: test/tb_midpoint_circle_rasterizer_core.sv
// Self-checking testbench for the midpoint circle rasterizer core: directed table, then random circles.
module tb_midpoint_circle_rasterizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = mcr_pkg::COORD_BITS_DEF;
    localparam int RW = mcr_pkg::RADIUS_BITS_DEF;
    localparam int OW = CW + 1;     // output coordinate width
    localparam int SW = RW + 1;     // loop x/y: radius plus sign (y dips to -1)
    localparam int DW = 16;         // decision term width
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES = 200;   // long receiver stall, fills the command queue
    localparam int TAIL_CYCLES = 10;    // generous margin after the last owed primitive
    localparam int MAX_REPORTS = 10;

    localparam logic MODE_OUTLINE = 1'b0;
    localparam logic MODE_FILL    = 1'b1;

    typedef logic signed [OW-1:0] coord_t;

    // One primitive: a point (start == end) or a horizontal span.
    typedef struct packed {
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
        logic   last;
    } prim_t;

    // Directed stimulus row; known rows carry a hand-typed primitive.
    typedef struct packed {
        logic                  op;
        logic signed [CW-1:0]  cx;
        logic signed [CW-1:0]  cy;
        logic [RW-1:0]         r;
        logic                  fill;
        logic                  known;
        prim_t                 want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_operation = mcr_pkg::OP_TICK;
    logic signed [CW-1:0]  s_center_x = '0;
    logic signed [CW-1:0]  s_center_y = '0;
    logic [RW-1:0]         s_radius = '0;
    logic                  s_fill_mode = MODE_OUTLINE;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    coord_t                m_x_start;
    coord_t                m_y_start;
    coord_t                m_x_end;
    coord_t                m_y_end;
    logic                  m_last_of_circle;

    // Predictor state: loop position, latched circle, place in the mirror set.
    logic signed [SW-1:0]  loop_x = '0;
    logic signed [SW-1:0]  loop_y = '0;
    logic signed [DW-1:0]  loop_d = '0;
    logic signed [CW-1:0]  ctr_x = '0;
    logic signed [CW-1:0]  ctr_y = '0;
    logic                  fill_on = MODE_OUTLINE;
    logic [2:0]            set_pos = '0;
    bit                    drawing = 1'b0;

    prim_t      pending_prims[$];   // primitives owed by the block, oldest first
    stim_row_t  stim_rows[$];
    int         words_sent = 0;     // starts plus ticks that produce a primitive
    int         fault_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;

    midpoint_circle_rasterizer_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_center_x       (s_center_x),
        .s_center_y       (s_center_y),
        .s_radius         (s_radius),
        .s_fill_mode      (s_fill_mode),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_x_start        (m_x_start),
        .m_y_start        (m_y_start),
        .m_x_end          (m_x_end),
        .m_y_end          (m_y_end),
        .m_last_of_circle (m_last_of_circle)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Midpoint circle step for one accepted word. A start arms the loop and
    // yields nothing; a tick while drawing yields the next primitive.
    function automatic void next_primitive(input logic op, input logic signed [CW-1:0] cx,
            input logic signed [CW-1:0] cy, input logic [RW-1:0] r, input logic fill,
            output bit made, output prim_t p);
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] u;
        logic signed [SW-1:0] v;
        coord_t               row;
        logic [2:0]           top;
        bit                   set_done;
        made = 1'b0;
        p = '0;
        if (op == mcr_pkg::OP_START) begin
            ctr_x = cx;
            ctr_y = cy;
            fill_on = fill;
            loop_x = '0;
            loop_y = signed'({1'b0, r});
            loop_d = DW'(mcr_pkg::D_INIT - 2 * int'(r));
            set_pos = '0;
            drawing = 1'b1;
        end else if (drawing) begin
            made = 1'b1;
            if (fill_on == MODE_FILL) begin
                // four spans per set, each cx+a .. cx-a on one row
                case (set_pos[1:0])
                    2'd0: begin
                        a = loop_x;
                        row = ctr_y + loop_y;
                    end
                    2'd1: begin
                        a = loop_x;
                        row = ctr_y - loop_y;
                    end
                    2'd2: begin
                        a = loop_y;
                        row = ctr_y + loop_x;
                    end
                    default: begin
                        a = loop_y;
                        row = ctr_y - loop_x;
                    end
                endcase
                p.xs = ctr_x + a;
                p.xe = ctr_x - a;
                p.ys = row;
                p.ye = row;
                top = 3'd3;
            end else begin
                // eight mirrored points; upper half swaps x and y
                if (set_pos < 3'd4) begin
                    u = loop_x;
                    v = loop_y;
                end else begin
                    u = loop_y;
                    v = loop_x;
                end
                p.xs = set_pos[0] ? ctr_x - u : ctr_x + u;
                p.ys = set_pos[1] ? ctr_y - v : ctr_y + v;
                p.xe = p.xs;
                p.ye = p.ys;
                top = 3'd7;
            end
            set_done = (set_pos >= top);
            p.last = set_done && (loop_y < loop_x);
            if (!set_done) begin
                set_pos = set_pos + 3'd1;
            end else if (p.last) begin
                set_pos = '0;
                drawing = 1'b0;
            end else begin
                set_pos = '0;
                loop_x = SW'(loop_x + 1);
                if (loop_d > 0) begin
                    loop_y = SW'(loop_y - 1);
                    loop_d = DW'(loop_d + 4 * (loop_x - loop_y) + mcr_pkg::STEP_DIAG);
                end else begin
                    loop_d = DW'(loop_d + 4 * loop_x + mcr_pkg::STEP_AXIAL);
                end
            end
        end
    endfunction

    function automatic void add_row(input logic op, input int cx, input int cy, input int r,
            input logic fill);
        stim_row_t entry;
        entry = '0;
        entry.op = op;
        entry.cx = CW'(cx);
        entry.cy = CW'(cy);
        entry.r = RW'(r);
        entry.fill = fill;
        stim_rows.push_back(entry);
    endfunction

    // Tick row with the primitive typed in by hand.
    function automatic void add_known(input int xs, input int ys, input int xe, input int ye,
            input logic last);
        stim_row_t entry;
        entry = '0;
        entry.op = mcr_pkg::OP_TICK;
        entry.known = 1'b1;
        entry.want.xs = OW'(xs);
        entry.want.ys = OW'(ys);
        entry.want.xe = OW'(xe);
        entry.want.ye = OW'(ye);
        entry.want.last = last;
        stim_rows.push_back(entry);
    endfunction

    // Offer one word (after random sender idle), wait for the handshake,
    // then book the primitive it owes.
    task automatic send_word(input logic op, input logic signed [CW-1:0] cx,
            input logic signed [CW-1:0] cy, input logic [RW-1:0] r, input logic fill,
            input logic known, input prim_t want);
        bit    made;
        prim_t got;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_center_x <= cx;
        s_center_y <= cy;
        s_radius <= r;
        s_fill_mode <= fill;
        do @(posedge aclk); while (!s_ready);
        next_primitive(op, cx, cy, r, fill, made, got);
        if (made || known) begin
            pending_prims.push_back(known ? want : got);
        end
        if (made || op == mcr_pkg::OP_START) begin
            words_sent++;
        end
    endtask

    // Tick with junk in the unused fields.
    task automatic send_tick();
        send_word(mcr_pkg::OP_TICK, CW'($urandom), CW'($urandom), RW'($urandom),
                  1'($urandom), 1'b0, '0);
    endtask

    // Random circles: mostly small radii run to their last word, a few full-range
    // radii cut short by the next start, some stray ticks while idle.
    task automatic run_circles(input int quota);
        int            stop_at;
        int            pick;
        int            ticks;
        logic [RW-1:0] r;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                r = RW'($urandom);
            end else begin
                r = RW'($urandom_range(0, 12));
            end
            send_word(mcr_pkg::OP_START, CW'($urandom), CW'($urandom), r, 1'($urandom),
                      1'b0, '0);
            ticks = (pick < 6 || pick >= 92) ? int'($urandom_range(0, 40)) : (1 << 20);
            while (drawing && ticks > 0) begin
                send_tick();
                ticks--;
            end
            if (pick >= 80 && pick < 92) begin
                repeat ($urandom_range(1, 3)) send_tick();
            end
        end
    endtask

    // Receiver: check each accepted word against the oldest owed primitive,
    // then pick m_ready for the next cycle (long hold when asked).
    always @(posedge aclk) begin : drain
        prim_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_prims.size() == 0) begin
                    if (fault_count < MAX_REPORTS) begin
                        $display("unexpected word: xs=%0d ys=%0d xe=%0d ye=%0d last=%0b",
                                 m_x_start, m_y_start, m_x_end, m_y_end, m_last_of_circle);
                    end
                    fault_count++;
                end else begin
                    want = pending_prims.pop_front();
                    if (m_x_start !== want.xs || m_y_start !== want.ys ||
                            m_x_end !== want.xe || m_y_end !== want.ye ||
                            m_last_of_circle !== want.last) begin
                        if (fault_count < MAX_REPORTS) begin
                            $display("mismatch: want xs=%0d ys=%0d xe=%0d ye=%0d last=%0b",
                                     want.xs, want.ys, want.xe, want.ye, want.last);
                            $display("          got  xs=%0d ys=%0d xe=%0d ye=%0d last=%0b",
                                     m_x_start, m_y_start, m_x_end, m_y_end,
                                     m_last_of_circle);
                        end
                        fault_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        // directed table
        add_row(mcr_pkg::OP_TICK, 0, 0, 0, MODE_OUTLINE);       // tick while idle: swallowed
        // most negative centre, max radius
        add_row(mcr_pkg::OP_START, -2048, -2048, 1023, MODE_OUTLINE);
        add_known(-2048, -1025, -2048, -1025, 1'b0);            // (+x,+y) with x = 0
        add_row(mcr_pkg::OP_TICK, 0, 0, 0, MODE_OUTLINE);
        add_row(mcr_pkg::OP_TICK, 0, 0, 0, MODE_OUTLINE);
        // restart mid-circle, max corner
        add_row(mcr_pkg::OP_START, 2047, 2047, 1023, MODE_FILL);
        add_known(2047, 3070, 2047, 3070, 1'b0);                // zero-width span at cy+r
        add_row(mcr_pkg::OP_TICK, 0, 0, 0, MODE_OUTLINE);
        add_row(mcr_pkg::OP_START, 5, -7, 0, MODE_FILL);        // zero radius, two sets
        repeat (7) add_row(mcr_pkg::OP_TICK, 0, 0, 0, MODE_OUTLINE);
        add_known(4, -8, 6, -8, 1'b1);                          // closing set past the diagonal
        add_row(mcr_pkg::OP_TICK, 0, 0, 0, MODE_OUTLINE);       // idle again after last
        add_row(mcr_pkg::OP_START, -1, 0, 1, MODE_OUTLINE);
        add_known(-1, 1, -1, 1, 1'b0);
        add_row(mcr_pkg::OP_TICK, 0, 0, 0, MODE_OUTLINE);
        add_row(mcr_pkg::OP_TICK, 0, 0, 0, MODE_OUTLINE);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 1: sender idles a little, receiver a lot
        send_idle_pct = 23;
        recv_idle_pct = 78;
        foreach (stim_rows[i]) begin
            send_word(stim_rows[i].op, stim_rows[i].cx, stim_rows[i].cy, stim_rows[i].r,
                      stim_rows[i].fill, stim_rows[i].known, stim_rows[i].want);
        end
        run_circles(700);

        // phase 2: roles swapped
        send_idle_pct = 78;
        recv_idle_pct = 23;
        run_circles(700);

        // phase 3: full rate; receiver stalls long once so the input side backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        run_circles(600);

        s_valid <= 1'b0;
        while (pending_prims.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
